[rtl/spf_pkg.sv]
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and the CRC-16 byte step for the packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Default frame size limit in bytes, header and CRC included.
  localparam int unsigned MAX_FRAME_DEF = 64;

  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [7:0]  MARK_BYTE  = 8'hFD;
  localparam logic [7:0]  RSVD_BYTE  = 8'h00;
  localparam logic [7:0]  DROP_BYTE  = 8'h00;

  // Header: FF FF FD 00 ID LEN_L LEN_H.
  localparam int unsigned HDR_LEN    = 7;
  localparam int unsigned HDR_IDX_W  = 3;
  // Bytes around the stuffed body: header plus two CRC bytes.
  localparam int unsigned FRAME_OVHD = 9;
  // The length field counts the stuffed body plus the CRC.
  localparam int unsigned LEN_OVHD   = 2;

  // Source of the next frame byte.
  typedef enum logic [2:0] {
    SRC_HDR   = 3'd0,
    SRC_BODY  = 3'd1,
    SRC_STUFF = 3'd2,
    SRC_CRCL  = 3'd3,
    SRC_CRCH  = 3'd4,
    SRC_DROP  = 3'd5
  } byte_src_e;

  typedef struct packed {
    logic      load;   // store an accepted body byte
    logic      start;  // begin emission of the loaded packet
    logic      fetch;  // read the next body byte from the store
    logic      emit;   // place a byte into the output register
    byte_src_e src;    // which byte to emit
    logic      clear;  // drop all packet state
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a byte this cycle
    logic too_long;    // loaded frame exceeds the limit
    logic hdr_last;    // emitting the final header byte
    logic body_done;   // every stored body byte has been fetched
    logic stuff_hit;   // current body byte closes an FF FF FD run
  } dp_status_t;

  // One byte of CRC-16, polynomial 0x8005, MSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[rtl/stuffed_packet_framer_crc16.sv]
// ----------------------------------------------------------------------------
// stuffed_packet_framer_crc16
// Collects one packet body and sends it as a byte-stuffed frame with CRC-16.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transaction carries
// s_axis    in         body byte, target ID, last-body-byte mark
// m_axis    out        frame byte, end-of-packet mark, dropped flag
//
// Each body byte is accepted as soon as it is offered while loading. After
// the last byte, the check state tests the frame length; a frame that is too
// long produces a single dropped transaction. Otherwise emission sends the
// seven header bytes, then for each body byte a fetch through the body
// store's registered read port and a write into the output register, then
// any inserted FD, and last the two CRC bytes. Reset clears the control
// state and counters; the body store is not cleared, since only bytes
// written in the current packet are ever read back. A stall on m_axis holds
// the output register and pauses emission. Input is taken only while
// loading, also while the last frame byte still waits.
//
// The frame is FF FF FD 00, ID, LEN_L, LEN_H, the stuffed body, CRC_L, CRC_H.
// An FD is inserted after every FF FF FD found in the original body bytes.
// LEN counts the stuffed body plus the two CRC bytes, and the CRC
// (polynomial 0x8005, zero start value, no reflection) covers every byte
// before it. Body bytes beyond MAX_FRAME are ignored; such a packet is
// always dropped.
module stuffed_packet_framer_crc16 import spf_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] body_byte, [15:8] target_id
  input  logic        s_axis_tlast_i,   // body_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] frame_byte
  output logic        m_axis_tlast_o,   // frame_end
  output logic [0:0]  m_axis_tuser_o    // [0] frame_dropped
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // The sequencer decides what happens each cycle; the datapath holds all
  // packet state and the output register.
  spf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spf_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .body_byte_i     (s_axis_tdata_i[7:0]),
    .target_id_i     (s_axis_tdata_i[15:8]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .frame_byte_o    (m_axis_tdata_o),
    .frame_end_o     (m_axis_tlast_o),
    .frame_dropped_o (m_axis_tuser_o[0])
  );

  // The last body byte hands control to the length check, so no further
  // body byte may be taken in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("body byte accepted right after the last body byte");

  // A dropped frame is reported as one single end-of-packet transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tlast_o && (m_axis_tdata_o == DROP_BYTE)))
    else $error("dropped flag on a transaction that is not the drop marker");

  // Emission never overwrites a byte that is still waiting on a stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("frame byte emitted into a full output register");

endmodule

[rtl/spf_datapath.sv]
// ----------------------------------------------------------------------------
// spf_datapath
// Body store, counters, stuffing detection, CRC and the output register.
// ----------------------------------------------------------------------------
module spf_datapath import spf_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_cmd_t   cmd_i,
  output dp_status_t status_o,
  input  logic [7:0] body_byte_i,
  input  logic [7:0] target_id_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o,
  output logic       frame_dropped_o
);

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);
  localparam int unsigned AW = $clog2(MAX_FRAME);
  localparam int unsigned TW = CW + 2;

  logic [7:0]           mem_q [MAX_FRAME];
  logic [7:0]           rdata_q;
  logic [CW-1:0]        body_cnt_q, body_cnt_d;
  logic [CW-1:0]        stuff_cnt_q, stuff_cnt_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic [HDR_IDX_W-1:0] hdr_idx_q, hdr_idx_d;
  logic [15:0]          prev_q, prev_d;
  logic [15:0]          crc_q, crc_d;
  logic [7:0]           id_q, id_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_end_q, out_end_d;
  logic                 out_drop_q, out_drop_d;
  logic                 has_room;
  logic [15:0]          len;
  logic [7:0]           hdr_byte;
  logic [7:0]           emit_byte;
  logic [TW-1:0]        total;

  assign has_room = body_cnt_q < CW'(MAX_FRAME);
  assign len      = 16'(body_cnt_q) + 16'(stuff_cnt_q) + 16'(LEN_OVHD);
  assign total    = TW'(body_cnt_q) + TW'(stuff_cnt_q) + TW'(FRAME_OVHD);

  always_comb begin
    unique case (hdr_idx_q)
      3'd0, 3'd1: hdr_byte = SYNC_BYTE;
      3'd2:       hdr_byte = MARK_BYTE;
      3'd3:       hdr_byte = RSVD_BYTE;
      3'd4:       hdr_byte = id_q;
      3'd5:       hdr_byte = len[7:0];
      3'd6:       hdr_byte = len[15:8];
      default:    hdr_byte = RSVD_BYTE;
    endcase
  end

  always_comb begin
    unique case (cmd_i.src)
      SRC_HDR:   emit_byte = hdr_byte;
      SRC_BODY:  emit_byte = rdata_q;
      SRC_STUFF: emit_byte = MARK_BYTE;
      SRC_CRCL:  emit_byte = crc_q[7:0];
      SRC_CRCH:  emit_byte = crc_q[15:8];
      SRC_DROP:  emit_byte = DROP_BYTE;
      default:   emit_byte = DROP_BYTE;
    endcase
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.too_long  = total > TW'(MAX_FRAME);
  assign status_o.hdr_last  = hdr_idx_q == HDR_IDX_W'(HDR_LEN - 1);
  assign status_o.body_done = rd_idx_q == body_cnt_q;
  assign status_o.stuff_hit = (rdata_q == MARK_BYTE) && (prev_q == {SYNC_BYTE, SYNC_BYTE});

  always_comb begin
    body_cnt_d  = body_cnt_q;
    stuff_cnt_d = stuff_cnt_q;
    rd_idx_d    = rd_idx_q;
    hdr_idx_d   = hdr_idx_q;
    prev_d      = prev_q;
    crc_d       = crc_q;
    id_d        = id_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_drop_d  = out_drop_q;

    if (cmd_i.load) begin
      if (body_cnt_q == '0) begin
        id_d = target_id_i;
      end
      if (has_room) begin
        body_cnt_d = body_cnt_q + 1'b1;
        if ((body_byte_i == MARK_BYTE) && (prev_q == {SYNC_BYTE, SYNC_BYTE}) &&
            (stuff_cnt_q < CW'(MAX_FRAME))) begin
          stuff_cnt_d = stuff_cnt_q + 1'b1;
        end
        prev_d = {prev_q[7:0], body_byte_i};
      end
    end

    // Emission replays the stored body, so the detector history restarts.
    if (cmd_i.start) begin
      prev_d    = '0;
      crc_d     = '0;
      rd_idx_d  = '0;
      hdr_idx_d = '0;
    end

    if (cmd_i.fetch) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_end_d   = (cmd_i.src == SRC_CRCH) || (cmd_i.src == SRC_DROP);
      out_drop_d  = cmd_i.src == SRC_DROP;
      if ((cmd_i.src == SRC_HDR) || (cmd_i.src == SRC_BODY) || (cmd_i.src == SRC_STUFF)) begin
        crc_d = crc16_byte(crc_q, emit_byte);
      end
      if (cmd_i.src == SRC_HDR) begin
        hdr_idx_d = hdr_idx_q + 1'b1;
      end
      if (cmd_i.src == SRC_BODY) begin
        prev_d = {prev_q[7:0], rdata_q};
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.clear) begin
      body_cnt_d  = '0;
      stuff_cnt_d = '0;
      prev_d      = '0;
      crc_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_cnt_q  <= '0;
      stuff_cnt_q <= '0;
      rd_idx_q    <= '0;
      hdr_idx_q   <= '0;
      prev_q      <= '0;
      crc_q       <= '0;
      id_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      body_cnt_q  <= body_cnt_d;
      stuff_cnt_q <= stuff_cnt_d;
      rd_idx_q    <= rd_idx_d;
      hdr_idx_q   <= hdr_idx_d;
      prev_q      <= prev_d;
      crc_q       <= crc_d;
      id_q        <= id_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
    out_drop_q <= out_drop_d;
  end

  // Body store: one write port on load, one registered read port on fetch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      mem_q[body_cnt_q[AW-1:0]] <= body_byte_i;
    end
    if (cmd_i.fetch) begin
      rdata_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign frame_end_o     = out_end_q;
  assign frame_dropped_o = out_drop_q;

endmodule

[rtl/spf_ctrl.sv]
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer for loading a packet body and emitting or dropping its frame.
// ----------------------------------------------------------------------------
module spf_ctrl import spf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_DROP  = 9'b000000100,
    S_HDR   = 9'b000001000,
    S_FETCH = 9'b000010000,
    S_BODY  = 9'b000100000,
    S_STUFF = 9'b001000000,
    S_CRCL  = 9'b010000000,
    S_CRCH  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_LOAD;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.src   = SRC_HDR;
    unique case (state_q)
      S_LOAD: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.start = 1'b1;
        state_d     = status_i.too_long ? S_DROP : S_HDR;
      end
      S_DROP: begin
        cmd_o.src = SRC_DROP;
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = S_LOAD;
        end
      end
      S_HDR: begin
        cmd_o.src = SRC_HDR;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.hdr_last) begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_BODY;
      end
      S_BODY: begin
        cmd_o.src = SRC_BODY;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.stuff_hit) begin
            state_d = S_STUFF;
          end else if (status_i.body_done) begin
            state_d = S_CRCL;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_STUFF: begin
        cmd_o.src = SRC_STUFF;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.body_done ? S_CRCL : S_FETCH;
        end
      end
      S_CRCL: begin
        cmd_o.src = SRC_CRCL;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_CRCH;
        end
      end
      S_CRCH: begin
        cmd_o.src = SRC_CRCH;
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sim/tb_stuffed_packet_framer_crc16.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_packet_framer_crc16
// Self-checking testbench for the byte-stuffed packet framer with CRC-16.
// ----------------------------------------------------------------------------
// Body bytes go in on s_axis and the frames that come out on m_axis are
// checked against a predictor that runs in the testbench. The predictor
// rebuilds each frame from the accepted body bytes: header, ID, length,
// stuffed body and CRC, or a single drop marker when the frame is too long.
// The run opens with a table of hand-picked packets: single bytes at the
// extremes, FF FF FD stuffing and near misses, and a run split across two
// packets. Random packets follow, mostly short, with some near the size
// limit and some past it. Both sides idle at random, and the receiver holds
// off once for a long stretch so that emission and input both stall.
// ----------------------------------------------------------------------------
module tb_stuffed_packet_framer_crc16;
  import spf_pkg::*;

  localparam int unsigned FRAME_LIMIT  = MAX_FRAME_DEF;
  localparam int          ITEM_GOAL    = 370;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       dropped;
  } frame_res_t;

  // One row of the directed table. n_exp is the number of frame bytes the
  // row should cause: zero for a body byte that is not the last one,
  // otherwise body + inserted FDs + 9.
  typedef struct packed {
    logic [7:0] body;
    logic [7:0] id;
    logic       fin;
    logic [7:0] n_exp;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    // Single-byte packets at both extremes, right after reset.
    {8'h00, 8'h00, 1'b1, 8'd10},
    {8'hFF, 8'hFF, 1'b1, 8'd10},
    // A plain FF FF FD run; the IDs after the first byte must be ignored.
    {8'hFF, 8'hA5, 1'b0, 8'd0},
    {8'hFF, 8'h5A, 1'b0, 8'd0},
    {8'hFD, 8'h00, 1'b1, 8'd13},
    // Three FFs before the FD still close a run.
    {8'hFF, 8'h5A, 1'b0, 8'd0},
    {8'hFF, 8'hFF, 1'b0, 8'd0},
    {8'hFF, 8'h00, 1'b0, 8'd0},
    {8'hFD, 8'h11, 1'b0, 8'd0},
    {8'h55, 8'h22, 1'b1, 8'd15},
    // A second FD right after a run is not stuffed again.
    {8'hFF, 8'h3C, 1'b0, 8'd0},
    {8'hFF, 8'hC3, 1'b0, 8'd0},
    {8'hFD, 8'h3C, 1'b0, 8'd0},
    {8'hFD, 8'hC3, 1'b1, 8'd14},
    // FF FD FF FD holds no run.
    {8'hFF, 8'hC3, 1'b0, 8'd0},
    {8'hFD, 8'h3C, 1'b0, 8'd0},
    {8'hFF, 8'h00, 1'b0, 8'd0},
    {8'hFD, 8'hFF, 1'b1, 8'd13},
    // Bit patterns around the sign bit.
    {8'h80, 8'h81, 1'b0, 8'd0},
    {8'h7F, 8'h7E, 1'b0, 8'd0},
    {8'h01, 8'h80, 1'b0, 8'd0},
    {8'hFE, 8'h01, 1'b1, 8'd13},
    // A run split across two packets must not be stuffed.
    {8'hFF, 8'h7E, 1'b0, 8'd0},
    {8'hFF, 8'h7E, 1'b1, 8'd11},
    {8'hFD, 8'hE7, 1'b1, 8'd10}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;    // [7:0] body_byte, [15:8] target_id
  logic        s_axis_tlast_i;    // body_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;    // [7:0] frame_byte
  logic        m_axis_tlast_o;    // frame_end
  logic [0:0]  m_axis_tuser_o;    // [0] frame_dropped

  // Predictor state: a copy of the packet being collected.
  logic [7:0]  body_copy [FRAME_LIMIT];
  int unsigned body_len;
  int unsigned stuff_len;
  logic [15:0] tail_two;
  logic [7:0]  id_copy;

  frame_res_t  expected_frame_bytes [$];
  int          items_taken;
  int          err_cnt;

  logic        rx_hold = 1'b0;
  int          rx_stall_left;
  int          rx_quiet_left;

  stuffed_packet_framer_crc16 #(
    .MAX_FRAME(FRAME_LIMIT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // CRC-16, polynomial 0x8005, zero start, MSB first, one bit at a time.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ d[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ 16'h8005;
      end
    end
    return crc;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_frame_byte(input logic [7:0] d, input logic fin, input logic drop);
    frame_res_t r;
    r.data    = d;
    r.last    = fin;
    r.dropped = drop;
    expected_frame_bytes.push_back(r);
  endtask

  // Takes one accepted body byte and, on the last one, queues the frame bytes
  // it causes. n_res returns how many were queued.
  task automatic predict_frame(input logic [7:0] b, input logic [7:0] id,
                               input logic fin, output int n_res);
    logic [15:0] crc;
    logic [15:0] run;
    logic [15:0] len;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  c;
    n_res = 0;
    if (body_len == 0) begin
      id_copy = id;
    end
    if (body_len < FRAME_LIMIT) begin
      body_copy[body_len] = b;
      body_len++;
      if (b == MARK_BYTE && tail_two == 16'hFFFF && stuff_len < FRAME_LIMIT) begin
        stuff_len++;
      end
      tail_two = {tail_two[7:0], b};
    end
    if (!fin) begin
      return;
    end

    if (body_len >= FRAME_LIMIT || body_len + stuff_len + FRAME_OVHD > FRAME_LIMIT) begin
      queue_frame_byte(DROP_BYTE, 1'b1, 1'b1);
      n_res = 1;
    end else begin
      len = 16'(body_len + stuff_len + LEN_OVHD);
      hdr = '{SYNC_BYTE, SYNC_BYTE, MARK_BYTE, RSVD_BYTE, id_copy, len[7:0], len[15:8]};
      crc = 16'h0000;
      foreach (hdr[i]) begin
        queue_frame_byte(hdr[i], 1'b0, 1'b0);
        crc = crc16_step(crc, hdr[i]);
      end
      n_res = HDR_LEN;
      // Stuffing looks only at the original body bytes, never at inserted FDs.
      run = 16'h0000;
      for (int i = 0; i < body_len; i++) begin
        c = body_copy[i];
        queue_frame_byte(c, 1'b0, 1'b0);
        crc = crc16_step(crc, c);
        n_res++;
        if (c == MARK_BYTE && run == 16'hFFFF) begin
          queue_frame_byte(MARK_BYTE, 1'b0, 1'b0);
          crc = crc16_step(crc, MARK_BYTE);
          n_res++;
        end
        run = {run[7:0], c};
      end
      queue_frame_byte(crc[7:0], 1'b0, 1'b0);
      queue_frame_byte(crc[15:8], 1'b1, 1'b0);
      n_res += 2;
    end
    body_len  = 0;
    stuff_len = 0;
    tail_two  = 16'h0000;
  endtask

  // Offers one body byte after an optional gap and waits for the transaction.
  task automatic send_body_byte(input logic [7:0] b, input logic [7:0] id,
                                input logic fin, output int n_res);
    int idle;
    idle = 0;
    // Every fourth stretch of 32 items runs without gaps.
    if ((items_taken / 32) % 4 != 3 && $urandom_range(0, 1) == 1) begin
      idle = pick_gap();
    end
    repeat (idle) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {id, b};
    s_axis_tlast_i  <= fin;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    items_taken++;
    predict_frame(b, id, fin, n_res);
  endtask

  task automatic send_random_packet();
    int          n;
    int          n_res;
    int unsigned sel;
    logic [7:0]  id;
    logic [7:0]  b;
    logic [7:0]  stray_id;
    sel = $urandom_range(0, 99);
    if (sel < 78) begin
      n = $urandom_range(1, 10);
    end else if (sel < 90) begin
      // Around the limit: 55 bytes fit only without any stuffing.
      n = $urandom_range(44, 55);
    end else begin
      // Too long, including packets that overflow the body store.
      n = $urandom_range(56, 70);
    end
    id = 8'($urandom);
    for (int k = 0; k < n; k++) begin
      // Heavy on FF and FD so that stuffing runs come up often.
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        b = SYNC_BYTE;
      end else if (sel < 5) begin
        b = MARK_BYTE;
      end else begin
        b = 8'($urandom);
      end
      stray_id = 8'($urandom);
      send_body_byte(b, (k == 0) ? id : stray_id, k == n - 1, n_res);
    end
  endtask

  // Receiver: random stalls, quiet stretches, and the long hold-off below.
  always @(negedge clk_i) begin
    if (rx_hold || rx_stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      if (rx_stall_left > 0) begin
        rx_stall_left--;
      end
    end else begin
      m_axis_tready_i <= 1'b1;
      if (rx_quiet_left > 0) begin
        rx_quiet_left--;
      end else if ($urandom_range(0, 99) < 30) begin
        rx_stall_left = pick_gap();
      end else if ($urandom_range(0, 99) < 3) begin
        rx_quiet_left = 100;
      end
    end
  end

  // Once a frame is under way, the receiver stops taking bytes for a long
  // while. The output register fills, emission pauses and the input stalls.
  initial begin : rx_hold_off
    wait (items_taken >= 60);
    do begin
      @(posedge clk_i);
    end while (!m_axis_tvalid_o);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin : frame_check
    frame_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_frame_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte %h last %b dropped %b", $time,
                 m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o[0]);
        err_cnt++;
      end else begin
        want = expected_frame_bytes.pop_front();
        if (m_axis_tdata_o !== want.data || m_axis_tlast_o !== want.last ||
            m_axis_tuser_o[0] !== want.dropped) begin
          $display("%0t: expected byte %h last %b dropped %b, got byte %h last %b dropped %b",
                   $time, want.data, want.last, want.dropped,
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o[0]);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stimulus
    int n_res;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    body_len        = 0;
    stuff_len       = 0;
    tail_two        = 16'h0000;
    id_copy         = 8'h00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_body_byte(DIR_ROWS[i].body, DIR_ROWS[i].id, DIR_ROWS[i].fin, n_res);
      if (n_res != DIR_ROWS[i].n_exp) begin
        $display("%0t: table row %0d expected %0d frame bytes, predicted %0d", $time,
                 i, DIR_ROWS[i].n_exp, n_res);
        err_cnt++;
      end
    end

    while (items_taken < ITEM_GOAL) begin
      send_random_packet();
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (expected_frame_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_frame_bytes.size() != 0) begin
      $display("%0t: %0d frame bytes never arrived", $time, expected_frame_bytes.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("[stuffed_packet_framer_crc16] OK");
    end else begin
      $display("[stuffed_packet_framer_crc16] ERROR");
    end
    $finish;
  end

  // Generous cap: well over the slowest correct run with every stall at its
  // longest.
  initial begin : watchdog
    #(100_000_000);
    $display("%0t: run timed out", $time);
    $display("[stuffed_packet_framer_crc16] ERROR");
    $finish;
  end

endmodule
